// ===== rtl/core/u8sv_pkg.sv =====
// Shared types and status codes for the UTF-8 stream validator.
`timescale 1ns / 1ps

package u8sv_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [2:0]  status_t;
    typedef logic [1:0]  pending_t;
    typedef logic [2:0]  char_len_t;
    typedef logic [20:0] code_point_t;

    localparam status_t ST_VALID      = 3'd0;
    localparam status_t ST_MISSING    = 3'd1;
    localparam status_t ST_INVALID    = 3'd2;
    localparam status_t ST_OVERLONG   = 3'd3;
    localparam status_t ST_RESTRICTED = 3'd4;

    localparam char_len_t LEN_NONE = 3'd0;
    localparam char_len_t LEN_TWO  = 3'd2;
    localparam char_len_t LEN_THREE = 3'd3;
    localparam char_len_t LEN_FOUR = 3'd4;

    localparam code_point_t SURR_LOW   = 21'h00D800;
    localparam code_point_t SURR_HIGH  = 21'h00DFFF;
    localparam code_point_t CP_MAX     = 21'h10FFFF;
    localparam code_point_t MIN_FOUR   = 21'h010000;
    localparam code_point_t MIN_THREE  = 21'h000800;
    localparam code_point_t MIN_TWO    = 21'h000080;

    localparam byte_t LEAD_RESTRICTED = 8'hF5;

endpackage

// ===== rtl/core/u8sv_byte_if.sv =====
// Byte transaction channel: data byte, last-byte mark and empty-string mark.
`timescale 1ns / 1ps

interface u8sv_byte_if;

    logic             valid;
    logic             ready;
    u8sv_pkg::byte_t  data_byte;
    logic             last_byte;
    logic             empty_string;

    modport source (output valid, output data_byte, output last_byte,
                    output empty_string, input ready);
    modport sink   (input valid, input data_byte, input last_byte,
                    input empty_string, output ready);

endinterface

// ===== rtl/core/u8sv_status_if.sv =====
// Status transaction channel: one validation result per string.
`timescale 1ns / 1ps

interface u8sv_status_if;

    logic              valid;
    logic              ready;
    u8sv_pkg::status_t status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);

endinterface

// ===== rtl/core/utf8_stream_validator.sv =====
// UTF-8 stream validator: per-byte decode state and registered string status.
// The status of a string is registered on its final transaction and appears in the cycle after it.
// Throughput: one byte transaction per cycle; the single status register
//   refills in the cycle it is drained, so input stalls only when it is held.
// Reset: rst_n clears the decode state and empties the status register.
`timescale 1ns / 1ps

module utf8_stream_validator (
    input logic           clk,
    input logic           rst_n,
    u8sv_byte_if.sink     bytes,
    u8sv_status_if.source result
);

    import u8sv_pkg::*;

    pending_t    expected_reg, expected_next;
    char_len_t   char_len_reg, char_len_next;
    code_point_t code_point_reg, code_point_next;
    logic        pend_inv_reg, pend_inv_next;
    logic        err_seen_reg, err_seen_next;
    status_t     err_code_reg, err_code_next;
    logic        out_valid_reg;
    status_t     status_reg, status_next;

    logic        accept;
    logic        ends_string;
    byte_t       c;
    pending_t    exp_dec;
    code_point_t cp_shift;
    logic        pi_cont;

    assign bytes.ready   = !out_valid_reg || result.ready;
    assign accept        = bytes.valid && bytes.ready;
    assign ends_string   = bytes.empty_string || bytes.last_byte;
    assign c             = bytes.data_byte;
    assign exp_dec       = expected_reg - 2'd1;
    assign cp_shift      = {code_point_reg[14:0], c[5:0]};
    assign pi_cont       = pend_inv_reg || (c[7:6] != 2'b10);
    assign result.valid  = out_valid_reg;
    assign result.status = status_reg;

    always_comb
    begin
        expected_next   = expected_reg;
        char_len_next   = char_len_reg;
        code_point_next = code_point_reg;
        pend_inv_next   = pend_inv_reg;
        err_seen_next   = err_seen_reg;
        err_code_next   = err_code_reg;
        status_next     = ST_VALID;

        if (!bytes.empty_string && !err_seen_reg)
        begin
            if (expected_reg == 2'd0)
            begin
                // decode lead byte
                pend_inv_next = 1'b0;
                if (!c[7])
                begin
                    pend_inv_next = 1'b0;
                end
                else if (c[7:5] == 3'b110)
                begin
                    expected_next   = 2'd1;
                    char_len_next   = LEN_TWO;
                    code_point_next = {16'd0, c[4:0]};
                end
                else if (c[7:4] == 4'b1110)
                begin
                    expected_next   = 2'd2;
                    char_len_next   = LEN_THREE;
                    code_point_next = {17'd0, c[3:0]};
                end
                else if (c[7:3] == 5'b11110)
                begin
                    if (c >= LEAD_RESTRICTED)
                    begin
                        err_seen_next = 1'b1;
                        err_code_next = ST_RESTRICTED;
                    end
                    else
                    begin
                        expected_next   = 2'd3;
                        char_len_next   = LEN_FOUR;
                        code_point_next = {18'd0, c[2:0]};
                    end
                end
                else
                begin
                    err_seen_next = 1'b1;
                    err_code_next = ST_INVALID;
                end
            end
            else
            begin
                // accumulate continuation byte
                expected_next   = exp_dec;
                code_point_next = cp_shift;
                pend_inv_next   = pi_cont;
                if (exp_dec == 2'd0)
                begin
                    if (pi_cont)
                    begin
                        err_seen_next = 1'b1;
                        err_code_next = ST_INVALID;
                    end
                    else if ((cp_shift >= SURR_LOW && cp_shift <= SURR_HIGH) ||
                             (cp_shift > CP_MAX))
                    begin
                        err_seen_next = 1'b1;
                        err_code_next = ST_RESTRICTED;
                    end
                    else if ((char_len_reg == LEN_FOUR && cp_shift < MIN_FOUR) ||
                             (char_len_reg == LEN_THREE && cp_shift < MIN_THREE) ||
                             (char_len_reg == LEN_TWO && cp_shift < MIN_TWO))
                    begin
                        err_seen_next = 1'b1;
                        err_code_next = ST_OVERLONG;
                    end
                    char_len_next   = LEN_NONE;
                    code_point_next = '0;
                    pend_inv_next   = 1'b0;
                end
            end
        end

        if (err_seen_next)
        begin
            status_next = err_code_next;
        end
        else if (expected_next != 2'd0)
        begin
            status_next = ST_MISSING;
        end

        if (ends_string)
        begin
            // drop string state
            expected_next   = 2'd0;
            char_len_next   = LEN_NONE;
            code_point_next = '0;
            pend_inv_next   = 1'b0;
            err_seen_next   = 1'b0;
            err_code_next   = ST_VALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg   <= 2'd0;
            char_len_reg   <= LEN_NONE;
            code_point_reg <= '0;
            pend_inv_reg   <= 1'b0;
            err_seen_reg   <= 1'b0;
            err_code_reg   <= ST_VALID;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                expected_reg   <= expected_next;
                char_len_reg   <= char_len_next;
                code_point_reg <= code_point_next;
                pend_inv_reg   <= pend_inv_next;
                err_seen_reg   <= err_seen_next;
                err_code_reg   <= err_code_next;
            end
            if (accept && ends_string)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && ends_string)
        begin
            status_reg <= status_next;
        end
    end

endmodule
